// ----- src/fdlm_pkg.sv -----
// shared types and constants for the fir delay line mac block
// no dependencies

package fdlm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 16;
    localparam int PROD_W   = 32;
    // eight products of 16x16 bits sum exactly in 35 bits
    localparam int ACC_W    = 35;
    localparam int FRAC_W   = 15;
    localparam int POS_W    = 3;
    localparam int NCOEFF   = 8;

    localparam logic MODE_PUSH  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // control for one delay line cell
    typedef struct packed {
        logic advance;  // take the neighbor's sample
        logic clear;    // zero the cell
    } cell_ctrl_t;

    // control for the multiply-accumulate unit
    typedef struct packed {
        logic start;    // zero the accumulator
        logic mul_en;   // form one product
    } mac_ctrl_t;

endpackage

// ----- src/fdlm_cell.sv -----
// one cell of the delay line: holds one sample and hands it to the next cell
// depends on fdlm_pkg

module fdlm_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  fdlm_pkg::cell_ctrl_t                ctrl,
    input  logic signed [fdlm_pkg::SAMPLE_W-1:0] d_in,
    output logic signed [fdlm_pkg::SAMPLE_W-1:0] q_out
);

    logic signed [fdlm_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [fdlm_pkg::SAMPLE_W-1:0] sample_next;

    always_comb begin
        sample_next = sample_reg;
        if (ctrl.clear) begin
            sample_next = '0;
        end else if (ctrl.advance) begin
            sample_next = d_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else begin
            sample_reg <= sample_next;
        end
    end

    assign q_out = sample_reg;

endmodule

// ----- src/fdlm_mac.sv -----
// multiply-accumulate unit with q1.15 scaling and 16 bit saturation
// depends on fdlm_pkg

module fdlm_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  fdlm_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [fdlm_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [fdlm_pkg::COEFF_W-1:0]  coeff,
    output logic signed [fdlm_pkg::SAMPLE_W-1:0] filter_out,
    output logic                                 saturated
);

    localparam int Q_W = fdlm_pkg::ACC_W - fdlm_pkg::FRAC_W;

    logic signed [fdlm_pkg::PROD_W-1:0] prod_reg;
    logic signed [fdlm_pkg::PROD_W-1:0] prod_next;
    logic                               prod_vld_reg;
    logic signed [fdlm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [fdlm_pkg::ACC_W-1:0]  acc_next;
    logic signed [Q_W-1:0]              q;
    logic                               sat_hi;
    logic                               sat_lo;

    assign prod_next = sample * coeff;

    always_comb begin
        acc_next = acc_reg;
        if (ctrl.start) begin
            acc_next = '0;
        end else if (prod_vld_reg) begin
            acc_next = acc_reg
                + {{(fdlm_pkg::ACC_W - fdlm_pkg::PROD_W){prod_reg[fdlm_pkg::PROD_W-1]}},
                   prod_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end else begin
            prod_vld_reg <= ctrl.mul_en;
            acc_reg      <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    // arithmetic shift floors toward minus infinity
    assign q      = acc_reg[fdlm_pkg::ACC_W-1:fdlm_pkg::FRAC_W];
    assign sat_hi = !q[Q_W-1] && (|q[Q_W-2:fdlm_pkg::SAMPLE_W-1]);
    assign sat_lo = q[Q_W-1] && !(&q[Q_W-2:fdlm_pkg::SAMPLE_W-1]);

    always_comb begin
        priority if (sat_hi) begin
            filter_out = {1'b0, {(fdlm_pkg::SAMPLE_W-1){1'b1}}};
        end else if (sat_lo) begin
            filter_out = {1'b1, {(fdlm_pkg::SAMPLE_W-1){1'b0}}};
        end else begin
            filter_out = q[fdlm_pkg::SAMPLE_W-1:0];
        end
    end

    assign saturated = sat_hi || sat_lo;

endmodule

// ----- src/fir_delay_line_mac_core.sv -----
// top level of the fir delay line mac: cell chain, mac unit, apb registers, stream ports
// depends on fdlm_pkg, fdlm_cell, fdlm_mac

// Direct-form FIR over a delay line of TAPS sample cells, newest sample in the
// first cell. A push transaction shifts the sample into the chain; the chain
// then rotates once per cycle past a single 16x16 multiplier, so one tap is
// multiplied and accumulated per cycle. After the rotation in ST_MAC, ST_DRAIN
// drains the pipelined accumulate and ST_DONE loads the result into the output
// register; the block then returns to ST_IDLE to accept the next item. A clear
// transaction goes from acceptance straight to ST_DONE. A result that waits in
// a full output register holds either kind of transaction in ST_DONE.
// The result register lets the next item be accepted while the previous
// result waits. The lagged value is captured from the chain tail as the
// requested position passes by. Coefficients are written through the APB port
// at byte address 4*k and should only change while idle.

module fir_delay_line_mac_core #(
    parameter int TAPS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: sample [15:0], read_position [18:16], zero [23:19]
    input  logic [23:0] s_tdata,
    // s_tuser: mode [0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: filter_out [15:0], lagged_value [31:16]
    output logic [31:0] m_tdata,
    // m_tuser: saturated [0]
    output logic        m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    localparam int SW = fdlm_pkg::SAMPLE_W;
    localparam int PW = fdlm_pkg::POS_W;

    // lag position wraps modulo TAPS; table over the eight codes
    function automatic logic [PW-1:0] wrap_pos(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = '0;
        for (int i = 0; i < (1 << PW); i++) begin
            if (p == PW'(i)) begin
                r = PW'(i % TAPS);
            end
        end
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] rpos_reg;
    logic signed [fdlm_pkg::COEFF_W-1:0] coeff_reg [fdlm_pkg::NCOEFF];
    logic signed [SW-1:0] lag_reg;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;
    logic        m_tvalid_reg;

    logic                 in_acc;
    logic                 in_push;
    logic                 in_clear;
    logic                 out_free;
    logic                 cfg_wr;
    fdlm_pkg::cell_ctrl_t cell_ctrl;
    fdlm_pkg::mac_ctrl_t  mac_ctrl;
    logic signed [SW-1:0] cell_q [TAPS];
    logic signed [SW-1:0] cell_d [TAPS];
    logic signed [SW-1:0] tail;
    logic [PW-1:0]        coeff_sel;
    logic signed [SW-1:0] filter_out;
    logic                 saturated;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_push  = in_acc && (s_tuser == fdlm_pkg::MODE_PUSH);
    assign in_clear = in_acc && (s_tuser == fdlm_pkg::MODE_CLEAR);
    assign out_free = !m_tvalid_reg || m_tready;
    assign tail     = cell_q[TAPS-1];

    // ring: cell 0 takes the new sample on push, the tail while rotating
    assign cell_ctrl.advance = in_push || (state_reg == ST_MAC);
    assign cell_ctrl.clear   = in_clear;

    generate
        for (genvar k = 0; k < TAPS; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign cell_d[k] = (state_reg == ST_MAC) ? tail : $signed(s_tdata[SW-1:0]);
            end else begin : g_body
                assign cell_d[k] = cell_q[k-1];
            end
            fdlm_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (cell_ctrl),
                .d_in    (cell_d[k]),
                .q_out   (cell_q[k])
            );
        end
    endgenerate

    // step j sees the sample at lag position j, weighted by coeff TAPS-1-j
    assign coeff_sel       = PW'(TAPS - 1) - cnt_reg;
    assign mac_ctrl.start  = in_acc;
    assign mac_ctrl.mul_en = (state_reg == ST_MAC);

    fdlm_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (mac_ctrl),
        .sample     (tail),
        .coeff      (coeff_reg[coeff_sel]),
        .filter_out (filter_out),
        .saturated  (saturated)
    );

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (in_push) begin
                    state_next = ST_MAC;
                end else if (in_clear) begin
                    state_next = ST_DONE;
                end
            end
            ST_MAC: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PW'(TAPS - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            rpos_reg <= wrap_pos(s_tdata[SW+PW-1:SW]);
        end
        if (in_clear) begin
            lag_reg <= '0;
        end else if ((state_reg == ST_MAC) && (cnt_reg == rpos_reg)) begin
            lag_reg <= tail;
        end
        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= {lag_reg, filter_out};
            m_tuser_reg <= saturated;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    // apb register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < fdlm_pkg::NCOEFF; i++) begin
                coeff_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            coeff_reg[paddr[4:2]] <= pwdata[fdlm_pkg::COEFF_W-1:0];
        end
    end

    assign prdata = {{(32 - fdlm_pkg::COEFF_W){1'b0}}, coeff_reg[paddr[4:2]]};

    a_onehot_state : assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_push_starts_mac : assert property (@(posedge aclk) disable iff (!aresetn)
        in_push |=> (state_reg == ST_MAC) && (cnt_reg == '0))
        else $error("push did not start the tap sweep");

    a_clear_zeroes_chain : assert property (@(posedge aclk) disable iff (!aresetn)
        in_clear |=> (cell_q[0] == '0) && (tail == '0) && (lag_reg == '0))
        else $error("clear did not zero the delay line");

    a_cnt_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (cnt_reg <= PW'(TAPS - 1)))
        else $error("tap counter beyond TAPS");

    a_result_only_when_free : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata) || (state_reg == ST_IDLE))
        else $error("pending result overwritten");

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for fir_delay_line_mac_core: stream driver, result monitor, apb writes
// depends on fdlm_pkg and fir_delay_line_mac_core

module tb;

    localparam int TAPS        = 8;
    localparam int LATENCY     = TAPS + 3;
    localparam int QUIET_LIMIT = 1000;
    localparam int SW          = fdlm_pkg::SAMPLE_W;
    localparam int PW          = fdlm_pkg::POS_W;
    localparam int CW          = fdlm_pkg::COEFF_W;
    localparam int NC          = fdlm_pkg::NCOEFF;

    typedef struct packed {
        logic          mode;
        logic [SW-1:0] sample;
        logic [PW-1:0] rpos;
    } fir_item_t;

    typedef struct packed {
        logic [SW-1:0] filter_out;
        logic [SW-1:0] lagged_value;
        logic          saturated;
    } fir_result_t;

    typedef enum int {CO_RANDOM, CO_MAX, CO_MIN, CO_SMALL, CO_DELAY, CO_ALT} coeff_kind_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = fdlm_pkg::MODE_PUSH;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [CW-1:0] coeff_model   [NC]   = '{default: '0};
    logic [SW-1:0] history_model [TAPS] = '{default: '0};
    int            oldest_idx = 0;

    fir_item_t   pending_items [$];
    fir_result_t results_due   [$];
    fir_item_t   cur_item;
    int          items_queued  = 0;
    int          items_taken   = 0;
    int          results_seen  = 0;
    int          error_count   = 0;
    int          src_gap       = 0;
    int          snk_stall     = 0;
    int          src_max_gap   = 5;
    int          snk_max_stall = 5;
    int          quiet_cycles  = 0;

    coeff_kind_t phase_sets [6] = '{CO_RANDOM, CO_SMALL, CO_DELAY, CO_ALT, CO_RANDOM, CO_SMALL};
    int          phase_gap  [6] = '{5, 0, 5, 0, 3, 5};
    int          phase_stall[6] = '{5, 0, 0, 5, 5, 2};

    fir_delay_line_mac_core #(.TAPS(TAPS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // fir output and lagged sample for one accepted transaction
    function automatic fir_result_t filter_step(input fir_item_t it);
        fir_result_t r;
        longint      acc;
        longint      q;
        r = '0;
        if (it.mode == fdlm_pkg::MODE_CLEAR) begin
            for (int k = 0; k < TAPS; k++)
                history_model[k] = '0;
            oldest_idx = 0;
            return r;
        end
        history_model[oldest_idx] = it.sample;
        oldest_idx = (oldest_idx + 1) % TAPS;
        acc = 0;
        // i = 0 is the oldest sample, weighted by the last coefficient
        for (int i = 0; i < TAPS; i++)
            acc += longint'($signed(coeff_model[TAPS-1-i]))
                 * longint'($signed(history_model[(oldest_idx + i) % TAPS]));
        q = acc >>> fdlm_pkg::FRAC_W;
        if (q > 32767) begin
            q = 32767;
            r.saturated = 1'b1;
        end else if (q < -32768) begin
            q = -32768;
            r.saturated = 1'b1;
        end
        r.filter_out   = q[SW-1:0];
        r.lagged_value = history_model[(oldest_idx + int'(it.rpos)) % TAPS];
        return r;
    endfunction

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic queue_item(input logic mode, input logic [15:0] sample, input logic [2:0] rpos);
        fir_item_t it;
        it.mode   = mode;
        it.sample = sample;
        it.rpos   = rpos;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_random_items(input int n);
        logic        mode;
        logic [15:0] sample;
        int          pick;
        for (int j = 0; j < n; j++) begin
            // clears stay rare so the delay line fills between them
            mode = ($urandom_range(0, 99) < 4) ? fdlm_pkg::MODE_CLEAR : fdlm_pkg::MODE_PUSH;
            pick = $urandom_range(0, 9);
            case (pick)
                0:       sample = 16'h7FFF;
                1:       sample = 16'h8000;
                2:       sample = 16'($urandom_range(0, 255) - 128);
                default: sample = 16'($urandom);
            endcase
            queue_item(mode, sample, 3'($urandom_range(0, 7)));
        end
    endtask

    task automatic reg_write(input int idx, input logic [15:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * 4);
        pwdata  <= {{16{val[15]}}, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        coeff_model[idx] = val;
    endtask

    task automatic apply_coeff_set(input coeff_kind_t kind);
        logic [15:0] v;
        int          hot;
        hot = $urandom_range(0, NC - 1);
        for (int k = 0; k < NC; k++) begin
            case (kind)
                CO_MAX:   v = 16'h7FFF;
                CO_MIN:   v = 16'h8000;
                CO_SMALL: v = 16'($urandom_range(0, 8191) - 4096);
                CO_DELAY: v = (k == hot) ? 16'h7FFF : 16'h0000;
                CO_ALT:   v = k[0] ? 16'h8000 : 16'h7FFF;
                default:  v = 16'($urandom);
            endcase
            reg_write(k, v);
        end
    endtask

    // block until every queued transaction has produced its checked result
    task automatic wait_idle();
        while (items_taken != items_queued || results_due.size() != 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                results_due.push_back(filter_step(cur_item));
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_tdata  <= {5'b0, cur_item.rpos, cur_item.sample};
                    s_tuser  <= cur_item.mode;
                    s_tvalid <= 1'b1;
                    src_gap = $urandom_range(0, src_max_gap);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : monitor
        fir_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_stall = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    note_error($sformatf("result %0d arrived with nothing expected", results_seen));
                end else begin
                    want = results_due.pop_front();
                    if (m_tdata[15:0] !== want.filter_out)
                        note_error($sformatf("result %0d filter_out expected %h got %h",
                                             results_seen, want.filter_out, m_tdata[15:0]));
                    if (m_tdata[31:16] !== want.lagged_value)
                        note_error($sformatf("result %0d lagged_value expected %h got %h",
                                             results_seen, want.lagged_value, m_tdata[31:16]));
                    if (m_tuser !== want.saturated)
                        note_error($sformatf("result %0d saturated expected %b got %b",
                                             results_seen, want.saturated, m_tuser));
                end
                snk_stall = $urandom_range(0, snk_max_stall);
            end else if (snk_stall > 0) begin
                snk_stall--;
            end
            m_tready <= (snk_stall == 0);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // coefficients still zero from reset
        queue_item(fdlm_pkg::MODE_PUSH, 16'h7FFF, 3'd7);
        queue_item(fdlm_pkg::MODE_PUSH, 16'h8000, 3'd0);
        queue_item(fdlm_pkg::MODE_PUSH, 16'h0001, 3'd6);
        queue_item(fdlm_pkg::MODE_CLEAR, 16'hFFFF, 3'd7);
        wait_idle();

        // full scale weights: positive saturation, every lag position, clear with a sample
        apply_coeff_set(CO_MAX);
        for (int k = 0; k < TAPS; k++)
            queue_item(fdlm_pkg::MODE_PUSH, 16'h7FFF, 3'(k));
        queue_item(fdlm_pkg::MODE_PUSH, 16'h8000, 3'd0);
        queue_item(fdlm_pkg::MODE_PUSH, 16'h8000, 3'd7);
        queue_item(fdlm_pkg::MODE_CLEAR, 16'h1234, 3'd5);
        queue_item(fdlm_pkg::MODE_PUSH, 16'h0001, 3'd7);
        wait_idle();

        // most negative weights against both sample extremes
        apply_coeff_set(CO_MIN);
        for (int k = 0; k < 4; k++)
            queue_item(fdlm_pkg::MODE_PUSH, 16'h8000, 3'(k));
        for (int k = 0; k < 4; k++)
            queue_item(fdlm_pkg::MODE_PUSH, 16'h7FFF, 3'(k + 4));
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            apply_coeff_set(phase_sets[ph]);
            src_max_gap   = phase_gap[ph];
            snk_max_stall = phase_stall[ph];
            queue_random_items(185);
            wait_idle();
        end

        repeat (LATENCY) @(posedge aclk);
        if (error_count == 0 && results_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
src/fdlm_pkg.sv
src/fdlm_cell.sv
src/fdlm_mac.sv
src/fir_delay_line_mac_core.sv
verif/tb.sv
